// File: src/value_table_search_update_delete_top_assert.svh
// Assertion macros shared by the value table modules.
// Each expects clk_i and rst_ni in scope.
`ifndef VALUE_TABLE_SEARCH_UPDATE_DELETE_TOP_ASSERT_SVH
`define VALUE_TABLE_SEARCH_UPDATE_DELETE_TOP_ASSERT_SVH

// Condition holds at every edge outside reset
`define VTSUD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define VTSUD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define VTSUD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/vtsud_pkg.sv
package vtsud_pkg;

  // Width of the position and count fields on the result word
  localparam int unsigned OUT_W = 7;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;      // latch key and new value
    logic    scan_start;   // restart the walk at entry 0
    logic    walk;         // step the read pointer through the table
    logic    append_wr;    // write new value at the end, bump count
    logic    upd_wr;       // overwrite the matched entry
    logic    shift_start;  // restart the walk just past the match
    logic    shift_wr;     // write each read entry one slot lower
    logic    dec_cnt;      // drop one entry from the count
    logic    set_pos_hit;  // position = match index + 1
    logic    clr_pos;      // position = 0
    logic    load_out;     // load the result word
    status_e status;       // status code for the result word
  } vtsud_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;        // registered read equals key
    logic exhausted;  // walk reached the count with nothing in flight
    logic full;       // count equals depth
  } vtsud_stat_t;

endpackage

// File: src/vtsud_datapath.sv
`include "value_table_search_update_delete_top_assert.svh"

module vtsud_datapath import vtsud_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vtsud_cmd_t               cmd_i,
  output vtsud_stat_t              stat_o,
  input  logic signed [31:0]       key_i,
  input  logic signed [31:0]       new_value_i,
  output logic        [1:0]        status_o,
  output logic        [OUT_W-1:0]  position_o,
  output logic        [OUT_W-1:0]  entry_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [31:0]   mem [DEPTH];

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rv_q, rv_d;
  logic [AW-1:0] cmp_idx_q;
  logic [31:0]   rd_q;
  logic [31:0]   key_q, nv_q;
  logic [CW-1:0] pos_q;
  logic [1:0]    out_status_q;
  logic [CW-1:0] out_pos_q, out_cnt_q;

  logic          issue;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  logic [CW+OUT_W-1:0] pos_ext, cnt_ext;

  // Read pointer walk shared by search and shift
  assign issue = cmd_i.walk && (idx_q < cnt_q);

  always_comb begin
    idx_d = idx_q;
    rv_d  = rv_q;
    cnt_d = cnt_q;
    if (cmd_i.scan_start) begin
      idx_d = '0;
      rv_d  = 1'b0;
    end else if (cmd_i.shift_start) begin
      idx_d = CW'(cmp_idx_q) + CW'(1);
      rv_d  = 1'b0;
    end else if (cmd_i.walk) begin
      rv_d = issue;
      if (issue) begin
        idx_d = idx_q + CW'(1);
      end
    end
    if (cmd_i.append_wr) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.dec_cnt) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      rv_q  <= rv_d;
    end
  end

  // Single write port: append, update or shift, never two at once
  always_comb begin
    we = 1'b0;
    wa = cmp_idx_q;
    wd = nv_q;
    if (cmd_i.append_wr) begin
      we = 1'b1;
      wa = cnt_q[AW-1:0];
    end else if (cmd_i.upd_wr) begin
      we = 1'b1;
    end else if (cmd_i.shift_wr && rv_q) begin
      we = 1'b1;
      wa = cmp_idx_q - AW'(1);
      wd = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read; cmp_idx_q tags the word in rd_q
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q      <= mem[idx_q[AW-1:0]];
      cmp_idx_q <= idx_q[AW-1:0];
    end
  end

  // Operands, position and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= key_i;
      nv_q  <= new_value_i;
    end
    if (cmd_i.append_wr) begin
      pos_q <= cnt_q + CW'(1);
    end else if (cmd_i.set_pos_hit) begin
      pos_q <= CW'(cmp_idx_q) + CW'(1);
    end else if (cmd_i.clr_pos) begin
      pos_q <= '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.status;
      out_pos_q    <= pos_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign stat_o.hit       = rv_q && (rd_q == key_q);
  assign stat_o.exhausted = !rv_q && !(idx_q < cnt_q);
  assign stat_o.full      = (cnt_q == DEPTH_C);

  assign pos_ext       = {{OUT_W{1'b0}}, out_pos_q};
  assign cnt_ext       = {{OUT_W{1'b0}}, out_cnt_q};
  assign status_o      = out_status_q;
  assign position_o    = pos_ext[OUT_W-1:0];
  assign entry_count_o = cnt_ext[OUT_W-1:0];

  `VTSUD_ASSERT(a_cnt_max, cnt_q <= DEPTH_C, "entry count above depth")
  `VTSUD_ASSERT_IMP(a_app_room, cmd_i.append_wr, cnt_q < DEPTH_C, "append into full table")
  `VTSUD_ASSERT_IMP(a_shift_in_range, cmd_i.shift_wr && rv_q, cmp_idx_q != '0 && CW'(cmp_idx_q) < cnt_q, "shift write outside valid entries")

endmodule

// File: src/vtsud_ctrl.sv
`include "value_table_search_update_delete_top_assert.svh"

module vtsud_ctrl import vtsud_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vtsud_cmd_t  cmd_o,
  input  vtsud_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_e;

  state_e  state_q, state_d;
  mode_e   mode_q, mode_d;
  status_e res_q, res_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    mode_d      = mode_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    // result word leaves when taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture    = 1'b1;
          cmd_o.scan_start = 1'b1;
          mode_d           = mode_e'(mode_i);
          state_d          = (mode_e'(mode_i) == MODE_APPEND) ? S_APPEND : S_SCAN;
        end
      end
      S_APPEND: begin
        if (stat_i.full) begin
          res_d         = ST_FULL;
          cmd_o.clr_pos = 1'b1;
        end else begin
          res_d           = ST_OK;
          cmd_o.append_wr = 1'b1;
        end
        state_d = S_FIN;
      end
      S_SCAN: begin
        cmd_o.walk = 1'b1;
        if (stat_i.hit) begin
          cmd_o.set_pos_hit = 1'b1;
          res_d             = ST_OK;
          case (mode_q)
            MODE_UPDATE: begin
              cmd_o.upd_wr = 1'b1;
              state_d      = S_FIN;
            end
            MODE_DELETE: begin
              cmd_o.shift_start = 1'b1;
              state_d           = S_SHIFT;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end else if (stat_i.exhausted) begin
          res_d         = ST_MISS;
          cmd_o.clr_pos = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_SHIFT: begin
        cmd_o.walk     = 1'b1;
        cmd_o.shift_wr = 1'b1;
        if (stat_i.exhausted) begin
          cmd_o.dec_cnt = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          cmd_o.status   = res_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_APPEND;
      res_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `VTSUD_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted word did not start a command")
  `VTSUD_ASSERT_NXT(a_load_shows, cmd_o.load_out, out_valid_o, "loaded result not presented")
  `VTSUD_ASSERT(a_one_write, $onehot0({cmd_o.append_wr, cmd_o.upd_wr, cmd_o.shift_wr}), "more than one table write command")

endmodule

// File: src/value_table_search_update_delete_top.sv
// Channel  Direction  Handshake               Fields
// in       input      in_valid_i/in_stall_o   mode_i, key_i, new_value_i
// out      output     out_valid_o/out_stall_i status_o, position_o, entry_count_o
//
// One command at a time. Search/update/delete walk the table one entry per cycle
// through the single registered read port; delete then moves the later entries
// down one slot. A result still stalled on the output holds the next command in
// its final state until that result is taken.
// Reset is asynchronous, active low; it empties the table (count to zero) at once.
// A stalled result holds; the next command is taken while it waits.
module value_table_search_update_delete_top import vtsud_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic        [1:0]       mode_i,
  input  logic signed [31:0]      key_i,
  input  logic signed [31:0]      new_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic        [1:0]       status_o,
  output logic        [OUT_W-1:0] position_o,
  output logic        [OUT_W-1:0] entry_count_o
);

  vtsud_cmd_t  cmd;
  vtsud_stat_t stat;

  // Command sequencer
  vtsud_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Table memory, count and result word
  vtsud_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .key_i         (key_i),
    .new_value_i   (new_value_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// File: test/value_table_search_update_delete_top_tb.sv
module value_table_search_update_delete_top_tb;
  import vtsud_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned NUM_PROBES = 24;
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 200;

  // One result word as seen on the output channel
  typedef struct packed {
    logic [1:0]       status;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] count;
  } table_reply_t;

  // Directed command, with an optional hand-written result
  typedef struct packed {
    mode_e            op;
    logic [31:0]      key;
    logic [31:0]      value;
    logic             typed;
    status_e          status;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] count;
  } probe_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic        [1:0]       mode_i;
  logic signed [31:0]      key_i;
  logic signed [31:0]      new_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic        [1:0]       status_o;
  logic        [OUT_W-1:0] position_o;
  logic        [OUT_W-1:0] entry_count_o;

  // Shadow copy of the table, updated as each command word is accepted
  logic [31:0]  shadow_vals [DEPTH];
  int unsigned  shadow_count;
  table_reply_t pending_replies [$];
  probe_row_t   probes [NUM_PROBES];

  int unsigned mismatches;
  int unsigned replies_checked;
  int unsigned hits, misses, full_rejects, full_visits, empty_visits;
  bit          quiet_traffic;

  value_table_search_update_delete_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .new_value_i  (new_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .entry_count_o(entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Linear-scan table: first match wins, delete closes the gap
  function automatic void predict_reply(input mode_e op, input logic [31:0] key,
                                        input logic [31:0] value, output table_reply_t rep);
    int unsigned idx;
    idx = shadow_count;
    rep.status = ST_OK;
    rep.position = '0;
    if (op == MODE_APPEND) begin
      if (shadow_count >= DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        shadow_vals[shadow_count] = value;
        shadow_count++;
        rep.position = OUT_W'(shadow_count);
      end
    end else begin
      for (int unsigned i = 0; i < shadow_count; i++) begin
        if (shadow_vals[i] == key) begin
          idx = i;
          break;
        end
      end
      if (idx >= shadow_count) begin
        rep.status = ST_MISS;
      end else begin
        rep.position = OUT_W'(idx + 1);
        if (op == MODE_UPDATE) begin
          shadow_vals[idx] = value;
        end else if (op == MODE_DELETE) begin
          for (int unsigned j = idx; j + 1 < shadow_count; j++) begin
            shadow_vals[j] = shadow_vals[j + 1];
          end
          shadow_count--;
        end
      end
    end
    rep.count = OUT_W'(shadow_count);
  endfunction

  // Corner patterns plus a small pool so duplicates show up often
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5, 6: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
  endtask

  // Drive one command word and wait for it to be taken
  task automatic send_word(input mode_e op, input logic [31:0] key, input logic [31:0] value,
                           input logic typed, input table_reply_t typed_rep);
    int unsigned gap;
    table_reply_t rep;
    gap = quiet_traffic ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= op;
    key_i       <= key;
    new_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_reply(op, key, value, rep);
    case (rep.status)
      ST_OK:   hits++;
      ST_MISS: misses++;
      default: full_rejects++;
    endcase
    if (shadow_count == DEPTH) full_visits++;
    if (shadow_count == 0) empty_visits++;
    pending_replies.push_back(typed ? typed_rep : rep);
  endtask

  // Result side: random stall, then take one word and compare it
  initial begin
    int unsigned hold;
    table_reply_t got, want;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = quiet_traffic ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      got = '{status: status_o, position: position_o, count: entry_count_o};
      replies_checked++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: status %0d pos %0d count %0d",
                                  got.status, got.position, got.count));
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.position !== want.position ||
            got.count !== want.count) begin
          report_mismatch($sformatf(
            "result %0d: exp status %0d pos %0d count %0d, got status %0d pos %0d count %0d",
            replies_checked, want.status, want.position, want.count,
            got.status, got.position, got.count));
        end
      end
    end
  end

  // Stimulus
  initial begin
    mode_e        op;
    logic [31:0]  key, value;
    table_reply_t typed_rep;
    bit           draining;
    int unsigned  r;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_APPEND;
    key_i         = '0;
    new_value_i   = '0;
    quiet_traffic = 1'b0;
    draining      = 1'b0;
    shadow_count  = 0;
    mismatches    = 0;
    replies_checked = 0;
    hits = 0; misses = 0; full_rejects = 0; full_visits = 0; empty_visits = 0;

    // Empty table, signed extremes, duplicates, ignored fields, shift on delete
    probes = '{
      '{MODE_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISS, 7'd0, 7'd0},
      '{MODE_UPDATE, 32'h0000_0005, 32'h0000_0009, 1'b1, ST_MISS, 7'd0, 7'd0},
      '{MODE_DELETE, 32'hffff_ffff, 32'h0000_0000, 1'b1, ST_MISS, 7'd0, 7'd0},
      '{MODE_APPEND, 32'hffff_ffff, 32'h8000_0000, 1'b1, ST_OK,   7'd1, 7'd1},
      '{MODE_APPEND, 32'h8000_0000, 32'h7fff_ffff, 1'b1, ST_OK,   7'd2, 7'd2},
      '{MODE_APPEND, 32'h7fff_ffff, 32'h0000_0000, 1'b1, ST_OK,   7'd3, 7'd3},
      '{MODE_APPEND, 32'h0000_0000, 32'hffff_ffff, 1'b1, ST_OK,   7'd4, 7'd4},
      '{MODE_APPEND, 32'h1234_5678, 32'h7fff_ffff, 1'b1, ST_OK,   7'd5, 7'd5},
      '{MODE_SEARCH, 32'h7fff_ffff, 32'h0000_0000, 1'b1, ST_OK,   7'd2, 7'd5},
      '{MODE_SEARCH, 32'h8000_0000, 32'hffff_ffff, 1'b1, ST_OK,   7'd1, 7'd5},
      '{MODE_SEARCH, 32'hffff_ffff, 32'hdead_beef, 1'b1, ST_OK,   7'd4, 7'd5},
      '{MODE_SEARCH, 32'h1234_5678, 32'h0000_0000, 1'b1, ST_MISS, 7'd0, 7'd5},
      '{MODE_UPDATE, 32'h7fff_ffff, 32'h0000_0001, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_SEARCH, 32'h7fff_ffff, 32'h0000_0000, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_DELETE, 32'h8000_0000, 32'h5555_5555, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_SEARCH, 32'h0000_0001, 32'haaaa_aaaa, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_DELETE, 32'h7fff_ffff, 32'h0000_0000, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_UPDATE, 32'h7fff_ffff, 32'h0000_0003, 1'b1, ST_MISS, 7'd0, 7'd3},
      '{MODE_DELETE, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_MISS, 7'd0, 7'd3},
      '{MODE_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_UPDATE, 32'hffff_ffff, 32'h8000_0000, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_DELETE, 32'h0000_0001, 32'h0000_0000, 1'b0, ST_OK,   7'd0, 7'd0},
      '{MODE_DELETE, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK,   7'd1, 7'd0},
      '{MODE_SEARCH, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_MISS, 7'd0, 7'd0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      typed_rep = '{status: probes[i].status, position: probes[i].position,
                    count: probes[i].count};
      send_word(probes[i].op, probes[i].key, probes[i].value, probes[i].typed, typed_rep);
    end

    // Fill to the top, bounce off it, then hit the last slot
    while (shadow_count < DEPTH) send_word(MODE_APPEND, $urandom, pick_word(), 1'b0, '0);
    send_word(MODE_APPEND, 32'h0, 32'h7fff_ffff, 1'b0, '0);
    send_word(MODE_APPEND, 32'hffff_ffff, 32'h8000_0000, 1'b0, '0);
    send_word(MODE_SEARCH, shadow_vals[DEPTH-1], 32'h0, 1'b0, '0);
    send_word(MODE_DELETE, shadow_vals[DEPTH-1], 32'h0, 1'b0, '0);

    // Random traffic sweeping the fill level between empty and full
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet_traffic = (n >= 300 && n < 380);
      if (!draining && shadow_count == DEPTH && $urandom_range(0, 3) == 0) draining = 1'b1;
      if (draining && shadow_count == 0) draining = 1'b0;
      r = $urandom_range(0, 99);
      if (r < (draining ? 10 : 65)) op = MODE_APPEND;
      else if (r < (draining ? 70 : 75)) op = MODE_DELETE;
      else op = ($urandom_range(0, 1) != 0) ? MODE_SEARCH : MODE_UPDATE;
      if (shadow_count > 0 && $urandom_range(0, 9) < (draining ? 9 : 7))
        key = shadow_vals[$urandom_range(0, shadow_count - 1)];
      else
        key = pick_word();
      r = $urandom_range(0, 9);
      if (r < 3) value = pick_word();
      else if (r < 5 && shadow_count > 0) value = shadow_vals[$urandom_range(0, shadow_count - 1)];
      else value = $urandom;
      send_word(op, key, value, 1'b0, '0);
    end
    quiet_traffic = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result words: %0d done/found, %0d no match, %0d full rejects.",
             replies_checked, hits, misses, full_rejects);
    $display("Table sat full after %0d commands and empty after %0d; %0d mismatches.",
             full_visits, empty_visits, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("value_table_search_update_delete_top: match");
    end else begin
      $display("value_table_search_update_delete_top: mismatch");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Timed out with %0d result words outstanding.", pending_replies.size());
    $display("value_table_search_update_delete_top: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/vtsud_pkg.sv
src/vtsud_datapath.sv
src/vtsud_ctrl.sv
src/value_table_search_update_delete_top.sv
test/value_table_search_update_delete_top_tb.sv
